// ----- rtl/ccc_pkg.sv -----
// Package for the calendar clock counter: request and result structs,
// calendar state struct, clamp limits and the month length function.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ccc_pkg;

  localparam logic KIND_TICK = 1'b0;
  localparam logic KIND_SET  = 1'b1;

  localparam int unsigned YEAR_BASE        = 2000;
  localparam int unsigned YEAR_SPAN        = 2000;
  localparam int unsigned YEAR_LAST_OFFSET = 99;
  localparam int unsigned MONTHS_PER_YEAR  = 12;
  localparam int unsigned MAX_DAY          = 31;
  localparam int unsigned HOURS_PER_DAY    = 24;
  localparam int unsigned MINUTES_PER_HOUR = 60;
  localparam int unsigned SECONDS_PER_MIN  = 60;
  localparam int unsigned FEB_DAYS_LEAP    = 29;
  localparam int unsigned FEB_DAYS         = 28;

  // year / 2000 == (year >> 4) / 125, taken as (x * 4195) >> 19 for 12-bit x
  localparam int unsigned DIV125_MUL   = 4195;
  localparam int unsigned DIV125_SHIFT = 19;

  typedef struct packed {
    logic        kind;
    logic [15:0] set_year;
    logic [7:0]  set_month;
    logic [7:0]  set_day;
    logic [7:0]  set_hour;
    logic [7:0]  set_minute;
    logic [7:0]  set_second;
  } in_item_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } out_item_t;

  typedef struct packed {
    logic [6:0] year_offset;
    logic [3:0] month_count;
    logic [4:0] day_count;
    logic [4:0] hour_count;
    logic [5:0] minute_count;
    logic [5:0] second_count;
  } cal_state_t;

  function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    case (month)
      4'd2:    len = leap ? 5'(FEB_DAYS_LEAP) : 5'(FEB_DAYS);
      4'd4:    len = 5'd30;
      4'd6:    len = 5'd30;
      4'd9:    len = 5'd30;
      4'd11:   len = 5'd30;
      default: len = 5'(MAX_DAY);
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/calendar_clock_counter_top.sv -----
// Top level of the calendar clock counter: input register, calendar state,
// result register. Uses ccc_pkg, ccc_set_clamp and ccc_tick.
//
// Each request (a one-second tick or a calendar set) returns one result: the
// calendar after the request is applied. An accepted request is held in the
// input register, then its result is registered in the result register; one
// request is taken every cycle while the result side keeps up. The calendar
// registers update in the cycle a request leaves the input register, so
// back-to-back requests see each other's effect. A set request takes a year
// modulo 2000 and clamps out-of-range fields to defaults.
`timescale 1ns / 1ps
`default_nettype none
module calendar_clock_counter_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  ccc_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  wire                 out_stall,
  output ccc_pkg::out_item_t  out_item
);
  import ccc_pkg::*;

  logic       req_valid_r;
  in_item_t   req_r;
  cal_state_t cal_r;
  cal_state_t cal_nxt;
  cal_state_t set_state;
  cal_state_t tick_state;
  logic       out_valid_r;
  out_item_t  out_r;
  out_item_t  out_nxt;
  logic       advance;

  ccc_set_clamp u_set_clamp (
    .req    (req_r),
    .loaded (set_state)
  );

  ccc_tick u_tick (
    .cur (cal_r),
    .nxt (tick_state)
  );

  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = req_valid_r && !advance;

  always_comb begin
    cal_nxt = (req_r.kind == KIND_SET) ? set_state : tick_state;
    out_nxt.year   = 12'(YEAR_BASE) + {5'd0, cal_nxt.year_offset};
    out_nxt.month  = cal_nxt.month_count;
    out_nxt.day    = cal_nxt.day_count;
    out_nxt.hour   = cal_nxt.hour_count;
    out_nxt.minute = cal_nxt.minute_count;
    out_nxt.second = cal_nxt.second_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r       <= 1'b0;
      out_valid_r       <= 1'b0;
      cal_r.year_offset  <= 7'd0;
      cal_r.month_count  <= 4'd1;
      cal_r.day_count    <= 5'd1;
      cal_r.hour_count   <= 5'd0;
      cal_r.minute_count <= 6'd0;
      cal_r.second_count <= 6'd0;
    end else begin
      if (!in_stall) begin
        req_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= req_valid_r;
      end
      if (advance && req_valid_r) begin
        cal_r <= cal_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      req_r <= in_item;
    end
    if (advance && req_valid_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r.month_count >= 4'd1 && cal_r.month_count <= 4'(MONTHS_PER_YEAR))
    else $error("calendar month out of range");

  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r.hour_count < 5'(HOURS_PER_DAY) && cal_r.minute_count < 6'(MINUTES_PER_HOUR)
    && cal_r.second_count < 6'(SECONDS_PER_MIN))
    else $error("calendar time out of range");

  a_day_year_range: assert property (@(posedge clk) disable iff (!rst_n)
    cal_r.day_count != 5'd0 && cal_r.year_offset <= 7'(YEAR_LAST_OFFSET))
    else $error("calendar day or year out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    req_valid_r && advance |=> out_valid_r && out_r == $past(out_nxt))
    else $error("request did not produce its result");

  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(req_valid_r && advance) |=> $stable(cal_r))
    else $error("calendar changed without a request");

endmodule
`default_nettype wire

// ----- rtl/ccc_set_clamp.sv -----
// Set path: reduces the requested year modulo 2000 and clamps every
// requested field to its default when out of range. Uses ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccc_set_clamp (
  input  ccc_pkg::in_item_t   req,
  output ccc_pkg::cal_state_t loaded
);
  import ccc_pkg::*;

  logic [24:0] quot_prod;
  logic [5:0]  quot;
  logic [16:0] quot_x2000;
  logic [15:0] year_rem;

  always_comb begin
    quot_prod  = 25'(req.set_year[15:4]) * 25'(DIV125_MUL);
    quot       = quot_prod[24:DIV125_SHIFT];
    quot_x2000 = {quot, 11'b0} - {6'b0, quot, 5'b0} - {7'b0, quot, 4'b0};
    year_rem   = req.set_year - quot_x2000[15:0];
  end

  always_comb begin
    loaded.year_offset  = (year_rem <= 16'(YEAR_LAST_OFFSET)) ? year_rem[6:0] : 7'd0;
    loaded.month_count  = (req.set_month == 8'd0 || req.set_month > 8'(MONTHS_PER_YEAR))
                          ? 4'd1 : req.set_month[3:0];
    loaded.day_count    = (req.set_day == 8'd0 || req.set_day > 8'(MAX_DAY))
                          ? 5'd1 : req.set_day[4:0];
    loaded.hour_count   = (req.set_hour >= 8'(HOURS_PER_DAY)) ? 5'd0 : req.set_hour[4:0];
    loaded.minute_count = (req.set_minute >= 8'(MINUTES_PER_HOUR))
                          ? 6'd0 : req.set_minute[5:0];
    loaded.second_count = (req.set_second >= 8'(SECONDS_PER_MIN))
                          ? 6'd0 : req.set_second[5:0];
  end

endmodule
`default_nettype wire

// ----- rtl/ccc_tick.sv -----
// Tick path: advances the calendar by one second with carries through
// minute, hour, day, month and year. Uses ccc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ccc_tick (
  input  ccc_pkg::cal_state_t cur,
  output ccc_pkg::cal_state_t nxt
);
  import ccc_pkg::*;

  logic [6:0] sec;
  logic [6:0] min;
  logic [5:0] hr;
  logic [5:0] dy;
  logic [4:0] mon;
  logic [7:0] yr;

  always_comb begin
    sec = {1'b0, cur.second_count} + 7'd1;
    min = {1'b0, cur.minute_count};
    hr  = {1'b0, cur.hour_count};
    dy  = {1'b0, cur.day_count};
    mon = {1'b0, cur.month_count};
    yr  = {1'b0, cur.year_offset};
    if (sec >= 7'(SECONDS_PER_MIN)) begin
      sec = 7'd0;
      min = min + 7'd1;
    end
    if (min >= 7'(MINUTES_PER_HOUR)) begin
      min = 7'd0;
      hr  = hr + 6'd1;
    end
    if (hr >= 6'(HOURS_PER_DAY)) begin
      hr = 6'd0;
      dy = dy + 6'd1;
    end
    if (dy > {1'b0, days_in_month(cur.month_count, cur.year_offset[1:0] == 2'b00)}) begin
      dy  = 6'd1;
      mon = mon + 5'd1;
    end
    if (mon > 5'(MONTHS_PER_YEAR)) begin
      mon = 5'd1;
      yr  = yr + 8'd1;
      if (yr > 8'(YEAR_LAST_OFFSET)) begin
        yr = 8'd0;
      end
    end
    nxt.second_count = sec[5:0];
    nxt.minute_count = min[5:0];
    nxt.hour_count   = hr[4:0];
    nxt.day_count    = dy[4:0];
    nxt.month_count  = mon[3:0];
    nxt.year_offset  = yr[6:0];
  end

endmodule
`default_nettype wire

// ----- dv/tb.sv -----
// Testbench for calendar_clock_counter_top: directed and random set/tick requests,
// each result checked against an in-bench calendar predictor.
// Depends on ccc_pkg and the RTL of calendar_clock_counter_top.
`timescale 1ns / 1ps
module tb;
  import ccc_pkg::*;

  localparam int HOLD_CYCLES = 64;
  localparam int MAX_REPORTS = 10;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  cal_state_t cal_now;
  out_item_t  cal_q[$];
  int         mismatches = 0;
  int         requests_sent = 0;
  bit         tx_idle_en = 1'b0;
  bit         rx_idle_en = 1'b0;
  int         hold_ticket = 0;
  int         hold_seen = 0;
  int         hold_left = 0;
  int         rx_burst = 0;

  calendar_clock_counter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [4:0] month_length(logic [3:0] m, logic [6:0] yoff);
    logic [4:0] len;
    if (m == 4'd4 || m == 4'd6 || m == 4'd9 || m == 4'd11) begin
      len = 5'd30;
    end else if (m == 4'd2) begin
      len = ((YEAR_BASE + yoff) % 4 == 0) ? 5'(FEB_DAYS_LEAP) : 5'(FEB_DAYS);
    end else begin
      len = 5'(MAX_DAY);
    end
    return len;
  endfunction

  function automatic cal_state_t advance_calendar(cal_state_t s, in_item_t r);
    int unsigned y, mo, d, h, mi, sec;
    if (r.kind == KIND_SET) begin
      y = r.set_year;
      if (y >= YEAR_SPAN) y = y % YEAR_SPAN;
      if (y > YEAR_LAST_OFFSET) y = 0;
      mo = r.set_month;
      if (mo == 0 || mo > MONTHS_PER_YEAR) mo = 1;
      d = r.set_day;
      if (d == 0 || d > MAX_DAY) d = 1;
      h = (r.set_hour > HOURS_PER_DAY - 1) ? 0 : r.set_hour;
      mi = (r.set_minute > MINUTES_PER_HOUR - 1) ? 0 : r.set_minute;
      sec = (r.set_second > SECONDS_PER_MIN - 1) ? 0 : r.set_second;
    end else begin
      y = s.year_offset;
      mo = s.month_count;
      d = s.day_count;
      h = s.hour_count;
      mi = s.minute_count;
      sec = s.second_count + 1;
      if (sec >= SECONDS_PER_MIN) begin
        sec = 0;
        mi++;
      end
      if (mi >= MINUTES_PER_HOUR) begin
        mi = 0;
        h++;
      end
      if (h >= HOURS_PER_DAY) begin
        h = 0;
        d++;
      end
      if (d > month_length(4'(mo), 7'(y))) begin
        d = 1;
        mo++;
      end
      if (mo > MONTHS_PER_YEAR) begin
        mo = 1;
        y++;
        if (y > YEAR_LAST_OFFSET) y = 0;
      end
    end
    s.year_offset = 7'(y);
    s.month_count = 4'(mo);
    s.day_count = 5'(d);
    s.hour_count = 5'(h);
    s.minute_count = 6'(mi);
    s.second_count = 6'(sec);
    return s;
  endfunction

  function automatic in_item_t set_req(int unsigned y, int unsigned mo, int unsigned d,
                                       int unsigned h, int unsigned mi, int unsigned sec);
    in_item_t r;
    r.kind = KIND_SET;
    r.set_year = 16'(y);
    r.set_month = 8'(mo);
    r.set_day = 8'(d);
    r.set_hour = 8'(h);
    r.set_minute = 8'(mi);
    r.set_second = 8'(sec);
    return r;
  endfunction

  function automatic in_item_t tick_req();
    in_item_t r;
    r = in_item_t'({$urandom, 25'($urandom)});
    r.kind = KIND_TICK;
    return r;
  endfunction

  // Offset 0..99 written raw, as 20xx, or with extra multiples of 2000.
  function automatic int unsigned year_field(int unsigned off);
    int unsigned y;
    case ($urandom_range(0, 2))
      0: y = off;
      1: y = YEAR_BASE + off;
      default: y = YEAR_SPAN * $urandom_range(2, 32) + off;
    endcase
    return y;
  endfunction

  task automatic send_request(in_item_t r);
    out_item_t e;
    in_valid <= 1'b1;
    in_item <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    cal_now = advance_calendar(cal_now, r);
    e.year = 12'(YEAR_BASE + cal_now.year_offset);
    e.month = cal_now.month_count;
    e.day = cal_now.day_count;
    e.hour = cal_now.hour_count;
    e.minute = cal_now.minute_count;
    e.second = cal_now.second_count;
    cal_q.push_back(e);
    requests_sent++;
    if (tx_idle_en && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  task automatic check_result(out_item_t got);
    out_item_t e;
    if (cal_q.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("tb: unexpected result %p", got);
    end else begin
      e = cal_q.pop_front();
      if (got.year !== e.year || got.month !== e.month || got.day !== e.day ||
          got.hour !== e.hour || got.minute !== e.minute || got.second !== e.second) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("tb: mismatch expected %0d-%0d-%0d %0d:%0d:%0d got %0d-%0d-%0d %0d:%0d:%0d",
                   e.year, e.month, e.day, e.hour, e.minute, e.second,
                   got.year, got.month, got.day, got.hour, got.minute, got.second);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_result(out_item);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_burst > 0) begin
        rx_burst--;
        out_stall <= 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        rx_burst = $urandom_range(0, 6);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic wait_drained();
    while (cal_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    send_request(tick_req());
    send_request(set_req(2099, 12, 31, 23, 59, 59));
    send_request(tick_req());
    send_request(set_req(2024, 2, 28, 23, 59, 59));
    send_request(tick_req());
    send_request(set_req(24, 2, 29, 23, 59, 59));
    send_request(tick_req());
    send_request(set_req(2023, 2, 28, 23, 59, 59));
    send_request(tick_req());
    send_request(set_req(2001, 2, 31, 10, 20, 30));
    send_request(tick_req());
    send_request(set_req(2010, 4, 30, 23, 59, 59));
    send_request(tick_req());
    send_request(set_req(16'hffff, 255, 255, 255, 255, 255));
    send_request(set_req(1999, 13, 32, 24, 60, 60));
    send_request(set_req(100, 0, 0, 23, 59, 59));
    send_request(set_req(4099, 12, 31, 0, 59, 59));
    send_request(tick_req());
    send_request(set_req(0, 0, 0, 0, 0, 0));
    send_request(set_req(64050, 6, 30, 23, 59, 59));
    send_request(tick_req());
    send_request(set_req(2050, 12, 31, 23, 59, 59));
    send_request(tick_req());
    send_request(tick_req());
  endtask

  // Mostly sets parked just before a rollover followed by ticks, plus noise sets and plain tick runs.
  task automatic random_requests(int unsigned count);
    int unsigned stop_at;
    int unsigned mode;
    int unsigned ticks;
    stop_at = requests_sent + count;
    while (requests_sent < stop_at) begin
      mode = $urandom_range(0, 9);
      if (mode < 6) begin
        send_request(set_req(year_field($urandom_range(0, 3) == 0 ? 99 : $urandom_range(0, 99)),
                             $urandom_range(0, 2) == 0 ? 12 : $urandom_range(1, 12),
                             $urandom_range(26, 31),
                             $urandom_range(0, 2) == 0 ? $urandom_range(0, 23) : 23,
                             $urandom_range(0, 3) == 0 ? $urandom_range(0, 59) : 59,
                             $urandom_range(50, 59)));
        ticks = $urandom_range(1, 12);
      end else if (mode < 8) begin
        send_request(in_item_t'({1'b1, 16'($urandom), 8'($urandom), $urandom}));
        ticks = $urandom_range(0, 3);
      end else begin
        ticks = $urandom_range(1, 70);
      end
      repeat (ticks) send_request(tick_req());
    end
  endtask

  task automatic test_random_calendar();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    random_requests(700);
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_requests(150);
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    random_requests(300);
  endtask

  task automatic test_output_hold();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    hold_ticket <= hold_ticket + 1;
    random_requests(80);
  endtask

  task automatic test_drain_pause();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    random_requests(40);
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    random_requests(40);
  endtask

  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    random_requests(300);
  endtask

  initial begin
    cal_now = '0;
    cal_now.month_count = 4'd1;
    cal_now.day_count = 5'd1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_calendar();
    test_output_hold();
    test_drain_pause();
    test_streaming();
    in_valid <= 1'b0;
    @(posedge clk);
    wait_drained();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && cal_q.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ccc_pkg.sv
rtl/ccc_set_clamp.sv
rtl/ccc_tick.sv
rtl/calendar_clock_counter_top.sv
dv/tb.sv
